// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define STS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define STS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Widths, divider constants and shared types for the timestamp smoother.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int TIME_W    = 64;
  localparam int CNT_W     = 16;
  localparam int ELAPSED_W = 48;
  localparam int DELTA_W   = CNT_W + 1;
  localparam int DIV_STEPS = TIME_W;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  typedef struct packed {
    logic busy;
    logic done;
  } sts_div_stat_t;

endpackage

// File: sv/sts_div.sv
// ----------------------------------------------------------------------------
// sts_div
// Restoring divider, one quotient bit per cycle, 64-bit by 48-bit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sts_div
  import sts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [TIME_W-1:0]    dividend,
  input  logic [ELAPSED_W-1:0] divisor,
  output sts_div_stat_t        stat,
  output logic [TIME_W-1:0]    quotient,
  output logic [ELAPSED_W-1:0] remainder
);

  logic [STEP_W-1:0]    step_r;
  logic                 done_r;
  logic [TIME_W-1:0]    quo_r;
  logic [ELAPSED_W-1:0] rem_r;
  logic [ELAPSED_W-1:0] dvs_r;

  logic [ELAPSED_W:0]   rem_sh;
  logic [ELAPSED_W:0]   rem_sub;
  logic                 ge;
  logic [ELAPSED_W-1:0] rem_nxt;

  assign rem_sh  = {rem_r, quo_r[TIME_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign rem_nxt = ge ? rem_sub[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        step_r <= STEP_W'(DIV_STEPS);
      end else if (step_r != '0) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (step_r != '0) begin
      quo_r <= {quo_r[TIME_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = step_r != '0;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `STS_ASSERT_NXT(a_done_after_last, step_r == STEP_W'(1) && !start, done_r, "divider missed done")
  `STS_ASSERT_IMP(a_rem_below_dvs, done_r && dvs_r != '0, rem_r < dvs_r, "remainder not below divisor")
  `STS_ASSERT_IMP(a_no_restart, start, step_r == '0, "divider restarted while busy")

endmodule

// File: sv/sample_timestamp_smoother.sv
// ----------------------------------------------------------------------------
// sample_timestamp_smoother
// Smooths sample arrival times using the sensor's wrapping sample counter.
// ----------------------------------------------------------------------------
// Usage: each input word carries a raw arrival time in ns and the sensor's
// 16-bit sample counter. Each accepted word yields exactly one output word
// with the smoothed time, a missed-sample flag and a resync flag. Both
// channels use valid/ready. The configuration port writes filter_enable
// (reset 1) with cfg_wr_en; write it only while the block is idle.
// A filtered word passes from acceptance to out_valid through the setup
// steps PREP and SUM, the divider state (64 one-bit steps that form the
// mean gap plus the done cycle), the rounding, expected-time and compare
// steps, and the load of the output register. The divider's
// one-bit-per-cycle loop is the longest part of that path. The first word
// after reset and any word while the filter is disabled go straight to the output step.
// The block takes one word at a time: in_ready is high only while the
// sequencer is idle, so a new word is taken only once the last one has
// reached the output register, and may be taken while a finished result
// still sits there.
// Reset (synchronous, active low) clears the filter state, the sequencer
// and the output valid flag, and sets filter_enable to 1.
// When the receiver stalls, the result holds in the output register; a
// following word runs through the sequencer and waits at its final step
// until the output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_timestamp_smoother
  import sts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TIME_W-1:0] in_arrival_time_ns,
  input  logic [15:0]       in_sample_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TIME_W-1:0] out_smoothed_time_ns,
  output logic              out_missed_flag,
  output logic              out_resync_flag
);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;
  localparam logic [2:0] ST_EXP  = 3'd5;
  localparam logic [2:0] ST_CMP  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  logic [2:0]           state_r;
  logic                 fe_r;

  // Filter state.
  logic                 started_r;
  logic [CNT_W-1:0]     prev_count_r;
  logic [ELAPSED_W-1:0] elapsed_r;
  logic [TIME_W-1:0]    gap_sum_r;
  logic [TIME_W-1:0]    expected_r;
  logic [TIME_W-1:0]    prev_raw_r;
  logic [TIME_W-1:0]    prev_out_r;

  // Per-word working registers.
  logic [TIME_W-1:0]    t_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DELTA_W-1:0]   delta_r;
  logic [TIME_W-1:0]    diff_r;
  logic [TIME_W-1:0]    mean_r;
  logic [TIME_W-1:0]    mean_m1_r;
  logic [TIME_W-1:0]    res_r;
  logic                 missed_r;
  logic                 resync_r;

  // Output register.
  logic                 out_valid_r;
  logic [TIME_W-1:0]    out_time_r;
  logic                 out_missed_r;
  logic                 out_resync_r;

  logic                 accept;
  logic                 out_free;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_nxt;
  logic [TIME_W-1:0]    gap_sum_nxt;
  logic                 round_up;
  logic [ELAPSED_W:0]   rem_x2;

  sts_div_stat_t        div_stat;
  logic [TIME_W-1:0]    div_quo;
  logic [ELAPSED_W-1:0] div_rem;

  assign in_ready = state_r == ST_IDLE;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Saturating sample count and wrapping gap sum.
  assign elapsed_sum = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(delta_r);
  assign elapsed_nxt = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
  assign gap_sum_nxt = gap_sum_r + diff_r;

  // Round half up: add one when twice the remainder reaches the divisor.
  assign rem_x2   = {div_rem, 1'b0};
  assign round_up = rem_x2 >= {1'b0, elapsed_r};

  sts_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_SUM),
    .dividend  (gap_sum_nxt),
    .divisor   (elapsed_nxt),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r <= 1'b1;
    end else if (cfg_wr_en) begin
      fe_r <= cfg_wr_data;
    end
  end

  // Sequencer and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      started_r    <= 1'b0;
      prev_count_r <= '0;
      elapsed_r    <= '0;
      gap_sum_r    <= '0;
      expected_r   <= '0;
      prev_raw_r   <= '0;
      prev_out_r   <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (!fe_r) begin
              state_r <= ST_OUT;
            end else if (!started_r) begin
              // First word starts the filter and passes straight through.
              started_r    <= 1'b1;
              elapsed_r    <= '0;
              prev_raw_r   <= in_arrival_time_ns;
              prev_out_r   <= in_arrival_time_ns;
              expected_r   <= in_arrival_time_ns;
              prev_count_r <= in_sample_count[CNT_W-1:0];
              state_r      <= ST_OUT;
            end else begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          prev_count_r <= cnt_r;
          state_r      <= ST_SUM;
        end
        ST_SUM: begin
          elapsed_r <= elapsed_nxt;
          gap_sum_r <= gap_sum_nxt;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_r <= ST_RND;
          end
        end
        ST_RND: begin
          state_r <= ST_EXP;
        end
        ST_EXP: begin
          expected_r <= expected_r + mean_m1_r;
          state_r    <= ST_CMP;
        end
        ST_CMP: begin
          expected_r <= (t_r > expected_r) ? prev_out_r + mean_r : t_r;
          prev_out_r <= (t_r > expected_r) ? prev_out_r + mean_r : t_r;
          prev_raw_r <= t_r;
          state_r    <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Working registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t_r      <= in_arrival_time_ns;
          cnt_r    <= in_sample_count[CNT_W-1:0];
          res_r    <= in_arrival_time_ns;
          missed_r <= 1'b0;
          resync_r <= fe_r && !started_r;
        end
      end
      ST_PREP: begin
        missed_r <= cnt_r != prev_count_r + 1'b1;
        delta_r  <= (cnt_r > prev_count_r) ? {1'b0, cnt_r} - {1'b0, prev_count_r}
                                           : {1'b1, cnt_r} - {1'b0, prev_count_r};
        diff_r   <= t_r - prev_raw_r;
      end
      ST_RND: begin
        // A zero sample count cannot occur once started; the mean is then 0.
        if (elapsed_r == '0) begin
          mean_r    <= '0;
          mean_m1_r <= '1;
        end else begin
          mean_r    <= div_quo + TIME_W'(round_up);
          mean_m1_r <= round_up ? div_quo : div_quo - 1'b1;
        end
      end
      ST_CMP: begin
        if (t_r > expected_r) begin
          res_r <= prev_out_r + mean_r;
        end else begin
          res_r    <= t_r;
          resync_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register decouples the receiver from the sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_time_r   <= res_r;
      out_missed_r <= missed_r;
      out_resync_r <= resync_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_smoothed_time_ns = out_time_r;
  assign out_missed_flag      = out_missed_r;
  assign out_resync_flag      = out_resync_r;

  `STS_ASSERT_NXT(a_started_holds, started_r, started_r, "filter lost its started state")
  `STS_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_r == ST_DIV, "divider done outside DIV")
  `STS_ASSERT_IMP(a_idle_div_quiet, in_ready, !div_stat.busy, "divider busy while idle")

endmodule

// File: sim/sample_timestamp_smoother_tb.sv
// ----------------------------------------------------------------------------
// sample_timestamp_smoother_tb
// Self-checking bench: a short table of directed words, then random sample
// streams under several idle patterns, checked against model or typed results.
// ----------------------------------------------------------------------------
module sample_timestamp_smoother_tb
  import sts_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD       = 8;
  localparam int FILTER_LATENCY   = 71;    // Acceptance to out_valid, filtered path.
  localparam int SINK_HOLD_CYCLES = 600;   // Long receiver hold-off for the pressure test.
  localparam int RANDOM_CHUNKS    = 20;
  localparam int CHUNK_WORDS      = 24;
  localparam int DIRECTED_ROWS    = 18;

  // One expected output word.
  typedef struct packed {
    logic [TIME_W-1:0] smoothed_ns;
    logic              missed;
    logic              resync;
  } smooth_result_t;

  // A row of the directed table either writes filter_enable or offers a word.
  typedef enum logic {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              cfg_value;
    logic [TIME_W-1:0] arrival_ns;
    logic [CNT_W-1:0]  count;
    logic              has_typed;   // Result typed in below rather than predicted.
    smooth_result_t    typed;
  } dir_row_t;

  typedef enum {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [TIME_W-1:0] in_arrival_time_ns;
  logic [15:0]       in_sample_count;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TIME_W-1:0] out_smoothed_time_ns;
  logic              out_missed_flag;
  logic              out_resync_flag;

  sample_timestamp_smoother dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_arrival_time_ns   (in_arrival_time_ns),
    .in_sample_count      (in_sample_count),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_smoothed_time_ns (out_smoothed_time_ns),
    .out_missed_flag      (out_missed_flag),
    .out_resync_flag      (out_resync_flag)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Directed table. Results are typed in only where they are obvious: the
  // first word after reset passes through with resync set, and in bypass the
  // raw time comes back with both flags clear. All other rows are predicted.
  // --------------------------------------------------------------------------
  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Write the reset value once so the register sees an explicit write early.
    '{ROW_CFG,    1'b1, 64'd0, 16'h0000, 1'b0, '{64'd0, 1'b0, 1'b0}},
    // First word starts the filter and passes straight through.
    '{ROW_SAMPLE, 1'b0, 64'd1000, 16'hFFFF, 1'b1, '{64'd1000, 1'b0, 1'b1}},
    // Counter wraps from all ones to zero, which is an in-order step.
    '{ROW_SAMPLE, 1'b0, 64'd2000, 16'h0000, 1'b0, '{64'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'd3000, 16'h0001, 1'b0, '{64'd0, 1'b0, 1'b0}},
    // Repeated counter value counts as a full wrap of the counter.
    '{ROW_SAMPLE, 1'b0, 64'd4000, 16'h0001, 1'b0, '{64'd0, 1'b0, 1'b0}},
    // Skipped samples.
    '{ROW_SAMPLE, 1'b0, 64'd4100, 16'h0005, 1'b0, '{64'd0, 1'b0, 1'b0}},
    // Raw time steps backwards, so the raw gap wraps and the gap sum shrinks.
    '{ROW_SAMPLE, 1'b0, 64'd3000, 16'h0006, 1'b0, '{64'd0, 1'b0, 1'b0}},
    // Raw time at the top of its range, then wrapping past zero.
    '{ROW_SAMPLE, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0, 16'h0007, 1'b0, '{64'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'h0000_0000_0000_0100, 16'h0008, 1'b0, '{64'd0, 1'b0, 1'b0}},
    // Bypass: raw time out, flags clear, filter state untouched.
    '{ROW_CFG,    1'b0, 64'd0, 16'h0000, 1'b0, '{64'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1,
      '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'd0, 16'h0000, 1'b1, '{64'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'h5555_5555_5555_5555, 16'hAAAA, 1'b1,
      '{64'h5555_5555_5555_5555, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 1'b1,
      '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0}},
    // Back to filtering; the state picks up where it was left.
    '{ROW_CFG,    1'b1, 64'd0, 16'h0000, 1'b0, '{64'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'hAAAA_AAAA_AAAA_B000, 16'h5556, 1'b0, '{64'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'hAAAA_AAAA_AAAA_B3E8, 16'h5557, 1'b0, '{64'd0, 1'b0, 1'b0}},
    '{ROW_SAMPLE, 1'b0, 64'hAAAA_AAAA_AAAA_B7D0, 16'h5558, 1'b0, '{64'd0, 1'b0, 1'b0}}
  };

  // --------------------------------------------------------------------------
  // Local copy of the filter state and its one register.
  // --------------------------------------------------------------------------
  logic                 flt_enable     = 1'b1;
  logic                 flt_started    = 1'b0;
  logic [CNT_W-1:0]     flt_last_count = '0;
  logic [ELAPSED_W-1:0] flt_elapsed    = '0;
  logic [TIME_W-1:0]    flt_gap_sum    = '0;
  logic [TIME_W-1:0]    flt_expected   = '0;
  logic [TIME_W-1:0]    flt_last_raw   = '0;
  logic [TIME_W-1:0]    flt_last_out   = '0;

  smooth_result_t pending_results[$];
  int             mismatch_count = 0;
  idle_mode_e     idle_mode      = IDLE_NONE;

  // Random stream generator state.
  logic [TIME_W-1:0] gen_time   = '0;
  logic [CNT_W-1:0]  gen_count  = '0;
  int unsigned       gen_period = 1000;

  // The main process bumps hold_requests; the receiver process serves each
  // request by holding out_ready low until its hold_left count runs out.
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;

  // Predicts one output word and advances the local filter state. The mean
  // gap is the gap sum over the elapsed sample count, rounded half up.
  function automatic smooth_result_t smooth_timestamp(input logic [TIME_W-1:0] raw_ns,
                                                      input logic [CNT_W-1:0]  count);
    smooth_result_t       res;
    logic [CNT_W-1:0]     next_count;
    logic [CNT_W:0]       count_step;
    logic [TIME_W-1:0]    divisor;
    logic [TIME_W-1:0]    quot;
    logic [TIME_W-1:0]    rem;
    logic [TIME_W-1:0]    mean_gap;
    res             = '0;
    res.smoothed_ns = raw_ns;
    if (!flt_enable) begin
      return res;
    end
    if (!flt_started) begin
      flt_started    = 1'b1;
      flt_elapsed    = '0;
      flt_last_raw   = raw_ns;
      flt_last_out   = raw_ns;
      flt_last_count = count;
      flt_expected   = raw_ns;
      res.resync     = 1'b1;
      return res;
    end
    next_count = flt_last_count + 1'b1;
    res.missed = (count != next_count);
    // A counter that did not move forward is taken as having wrapped.
    if (count > flt_last_count) begin
      count_step = {1'b0, count} - {1'b0, flt_last_count};
    end else begin
      count_step = {1'b1, count} - {1'b0, flt_last_count};
    end
    flt_last_count = count;
    if (count_step > ELAPSED_MAX - flt_elapsed) begin
      flt_elapsed = ELAPSED_MAX;
    end else begin
      flt_elapsed = flt_elapsed + count_step;
    end
    flt_gap_sum = flt_gap_sum + (raw_ns - flt_last_raw);
    divisor     = {{(TIME_W - ELAPSED_W){1'b0}}, flt_elapsed};
    if (divisor == '0) begin
      mean_gap = '0;
    end else begin
      quot     = flt_gap_sum / divisor;
      rem      = flt_gap_sum % divisor;
      mean_gap = (rem >= divisor - rem) ? quot + 1'b1 : quot;
    end
    flt_expected = flt_expected + mean_gap - 1'b1;
    if (raw_ns > flt_expected) begin
      res.smoothed_ns = flt_last_out + mean_gap;
      flt_expected    = res.smoothed_ns;
    end else begin
      flt_expected    = raw_ns;
      res.smoothed_ns = raw_ns;
      res.resync      = 1'b1;
    end
    flt_last_raw = raw_ns;
    flt_last_out = res.smoothed_ns;
    return res;
  endfunction

  // Offers one word, holds it until the handshake, then records what the
  // block should return for it. Returns in the step of the accepting edge,
  // with in_valid still high so a following word can go back to back.
  task automatic offer_sample(input logic [TIME_W-1:0] raw_ns,
                              input logic [CNT_W-1:0]  count,
                              input logic              has_typed,
                              input smooth_result_t    typed);
    int unsigned    idle_pct;
    smooth_result_t predicted;
    idle_pct = (idle_mode == IDLE_SENDER) ? 80 : (idle_mode == IDLE_BOTH) ? 22 : 0;
    // Now and then a long gap, so idle time lands anywhere in the block's
    // filtering sequence and not only right after in_ready rises.
    if (idle_pct != 0 && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_arrival_time_ns <= raw_ns;
    in_sample_count    <= count;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = smooth_timestamp(raw_ns, count);
    pending_results.push_back(has_typed ? typed : predicted);
  endtask

  // Drops valid and waits until every expected word has come back. Every
  // word yields a result, so the block is idle once the queue is empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic write_filter_enable(input logic enable);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= enable;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    flt_enable  = enable;
  endtask

  // One random stream segment. Most words follow a steady sample clock with
  // jitter and an incrementing counter, which is what keeps the filter in its
  // smoothing state. The rest skip samples, repeat the counter, arrive early
  // or backwards (may force a resync), or are plain noise over the full width.
  task automatic run_random_chunk(input logic with_hold);
    int unsigned pick;
    int unsigned skip;
    if ($urandom_range(0, 3) == 0) begin
      gen_period = $urandom_range(1, 100);
    end else if ($urandom_range(0, 7) == 0) begin
      gen_period = $urandom;
    end else begin
      gen_period = $urandom_range(1000, 5_000_000);
    end
    if ($urandom_range(0, 3) == 0) begin
      gen_time = {$urandom, $urandom};
    end
    for (int i = 0; i < CHUNK_WORDS; i++) begin
      if (with_hold && i == 2) begin
        hold_requests <= hold_requests + 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        gen_count = gen_count + 1'b1;
        gen_time  = gen_time + gen_period - gen_period / 8 + $urandom_range(0, gen_period / 4);
      end else if (pick < 87) begin
        skip      = $urandom_range(2, 6);
        gen_count = gen_count + CNT_W'(skip);
        gen_time  = gen_time + 64'(skip) * gen_period;
      end else if (pick < 90) begin
        gen_time = gen_time + gen_period;
      end else if (pick < 94) begin
        gen_count = gen_count + 1'b1;
        gen_time  = gen_time + $urandom_range(0, gen_period / 2);
      end else if (pick < 96) begin
        gen_count = gen_count + 1'b1;
        gen_time  = gen_time - $urandom_range(0, gen_period);
      end else begin
        gen_time  = {$urandom, $urandom};
        gen_count = CNT_W'($urandom);
      end
      offer_sample(gen_time, gen_count, 1'b0, '0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver. It either serves a long hold request, stalls at random for the
  // current idle mode, or accepts every cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served <= hold_requests;
      hold_left    <= SINK_HOLD_CYCLES;
      out_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (idle_mode == IDLE_RECEIVER) begin
      out_ready <= ($urandom_range(0, 99) >= 80);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(0, 99) >= 22);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result check: every accepted output word is compared with the oldest
  // expectation, one field at a time.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    smooth_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected output word: expected none, got time %h missed %b resync %b",
                 $time, out_smoothed_time_ns, out_missed_flag, out_resync_flag);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_smoothed_time_ns !== want.smoothed_ns) begin
          $display("%0t ns: smoothed_time_ns mismatch: expected %h, got %h",
                   $time, want.smoothed_ns, out_smoothed_time_ns);
          mismatch_count++;
        end
        if (out_missed_flag !== want.missed) begin
          $display("%0t ns: missed_flag mismatch: expected %b, got %b",
                   $time, want.missed, out_missed_flag);
          mismatch_count++;
        end
        if (out_resync_flag !== want.resync) begin
          $display("%0t ns: resync_flag mismatch: expected %b, got %b",
                   $time, want.resync, out_resync_flag);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    in_valid           = 1'b0;
    in_arrival_time_ns = '0;
    in_sample_count    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, walked straight from the table with no idling.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_CFG) begin
        drain_results();
        write_filter_enable(DIRECTED[i].cfg_value);
      end else begin
        offer_sample(DIRECTED[i].arrival_ns, DIRECTED[i].count,
                     DIRECTED[i].has_typed, DIRECTED[i].typed);
      end
    end

    // Random part. Each chunk starts from an idle block, which is also where
    // the sender waits out every result before the register changes. Idle
    // modes rotate so every mode meets both register settings; chunk 4 runs
    // without random idling and carries the long receiver hold-off, so the
    // output register and the sequencer fill up and in_ready drops.
    gen_time  = flt_last_raw;
    gen_count = flt_last_count;
    for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
      drain_results();
      idle_mode = idle_mode_e'(chunk % 4);
      write_filter_enable((chunk % 5 == 2) ? 1'b0 : 1'b1);
      run_random_chunk(chunk == 4);
    end

    drain_results();
    repeat (2 * FILTER_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
